/* hw/rtl/slri_pkg.sv */
// Shared types and constants for the sorted insert/remove store.
// Used by the channel interfaces, the storage cell and the top level.
package slri_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  // Broadcast command seen by every cell in the row.
  typedef struct packed {
    logic                       ins_en;
    logic                       rm_en;
    logic                       rm_hit;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic                       valid;
    logic                       ge_ins;
  } link_t;

endpackage

/* hw/rtl/slri_req_if.sv */
// Request channel: valid/ready handshake with mode and value payload.
// Depends on slri_pkg.
interface slri_req_if;
  logic                               valid;
  logic                               ready;
  slri_pkg::mode_e                    mode;
  logic signed [slri_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

/* hw/rtl/slri_rsp_if.sv */
// Response channel: valid/ready handshake with found, full_reject, count.
// Depends on slri_pkg.
interface slri_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic                           full_reject;
  logic [slri_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output found, output full_reject, output count, input ready);
  modport sink   (input valid, input found, input full_reject, input count, output ready);
endinterface

/* hw/rtl/slri_cell.sv */
// One slot of the sorted row: holds a value and its valid bit.
// Depends on slri_pkg for the command and neighbor link types.
module slri_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slri_pkg::cmd_t       cmd_i,
  input  slri_pkg::link_t      left_i,
  input  slri_pkg::link_t      right_i,
  output slri_pkg::link_t      self_o,
  output logic                 eq_o
);

  logic signed [slri_pkg::VALUE_W-1:0] value_q, value_d;
  logic                                valid_q, valid_d;
  logic                                gt, ge_rm;

  always_comb begin
    gt    = valid_q && (value_q > cmd_i.value);
    ge_rm = valid_q && (value_q >= cmd_i.value);
    eq_o  = valid_q && (value_q == cmd_i.value);

    self_o.value  = value_q;
    self_o.valid  = valid_q;
    self_o.ge_ins = gt || !valid_q;

    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.ins_en && self_o.ge_ins) begin
      if (left_i.ge_ins) begin
        // shift right: take the left neighbor
        value_d = left_i.value;
        valid_d = left_i.valid;
      end else begin
        // insertion point
        value_d = cmd_i.value;
        valid_d = 1'b1;
      end
    end else if (cmd_i.rm_en && cmd_i.rm_hit && ge_rm) begin
      // close the gap: take the right neighbor
      value_d = right_i.value;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* hw/rtl/sorted_list_insert_remove_top.sv */
// Top level of the sorted insert/remove store: a row of slri_cell slots,
// the entry counter and the response register. Depends on slri_pkg,
// slri_req_if, slri_rsp_if and slri_cell.
//
//   channel  | dir | payload                      | transfer when
//   ---------+-----+------------------------------+-----------------------
//   req_i    | in  | mode, value                  | req_i.valid & ready
//   rsp_o    | out | found, full_reject, count    | rsp_o.valid & ready
//
// On each request the value is broadcast to all CAPACITY cells, each compares
// it with its own entry, and the row shifts one place right (insert, unless
// full) or left (remove that finds the value) at the edge that takes the
// request. One response per request appears in the cycle after the transfer.
// Reset empties the store by clearing the valid bits and the counter.
// A new request is taken while the response register is empty or drains in
// the same cycle; a stalled response holds the request side.
module sorted_list_insert_remove_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  slri_req_if.sink     req_i,
  slri_rsp_if.source   rsp_o
);

  localparam int unsigned N = slri_pkg::CAPACITY;

  slri_pkg::cmd_t                   cmd;
  slri_pkg::link_t                  links   [N];
  slri_pkg::link_t                  left_in [N];
  slri_pkg::link_t                  right_in[N];
  logic            [N-1:0]          eq_vec;
  logic            [N-1:0]          valid_vec;

  logic                             req_xfer;
  logic                             full;
  logic                             hit;
  logic [slri_pkg::CNT_W-1:0]       count_q, count_d;

  logic                             rsp_valid_q, rsp_valid_d;
  logic                             found_q, found_d;
  logic                             reject_q, reject_d;
  logic [slri_pkg::COUNT_W-1:0]     rsp_count_q, rsp_count_d;

  // Take a request whenever the response slot is free or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_xfer    = req_i.valid && req_i.ready;

  assign full = (count_q == slri_pkg::CNT_W'(N));
  assign hit  = |eq_vec;

  always_comb begin
    cmd.value  = req_i.value;
    cmd.ins_en = req_xfer && (req_i.mode == slri_pkg::MODE_INSERT) && !full;
    cmd.rm_en  = req_xfer && (req_i.mode == slri_pkg::MODE_REMOVE);
    cmd.rm_hit = hit;
  end

  // Wire the row: cell 0 has no left neighbor, the last cell no right one.
  for (genvar i = 0; i < N; i++) begin : g_row
    if (i == 0) begin : g_first
      assign left_in[i] = '{value: '0, valid: 1'b0, ge_ins: 1'b0};
    end else begin : g_mid_l
      assign left_in[i] = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_in[i] = '{value: '0, valid: 1'b0, ge_ins: 1'b0};
    end else begin : g_mid_r
      assign right_in[i] = links[i+1];
    end

    slri_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .self_o  (links[i]),
      .eq_o    (eq_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // Advance the counter and load the response.
  always_comb begin
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    found_d     = found_q;
    reject_d    = reject_q;
    if (cmd.ins_en) begin
      count_d = count_q + slri_pkg::CNT_W'(1);
    end else if (cmd.rm_en && hit) begin
      count_d = count_q - slri_pkg::CNT_W'(1);
    end
    rsp_count_d = rsp_count_q;
    if (req_xfer) begin
      rsp_valid_d = 1'b1;
      found_d     = cmd.rm_en && hit;
      reject_d    = (req_i.mode == slri_pkg::MODE_INSERT) && full;
      rsp_count_d = slri_pkg::COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= found_d;
    reject_q    <= reject_d;
    rsp_count_q <= rsp_count_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.full_reject = reject_q;
  assign rsp_o.count       = rsp_count_q;

  // Valid cells always form a prefix whose length is the counter.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slri_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // A refused insert leaves the count alone.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req_i.mode == slri_pkg::MODE_INSERT && full) |=> (count_q == $past(count_q)))
    else $error("refused insert changed the count");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(found_q && reject_q))
    else $error("found and full_reject both set");

endmodule
